// ===== design/ccs_pkg.sv =====
// Shared constants, types and codes for the circular channel seek block.
package ccs_pkg;

  // Table geometry.
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Field widths fixed by the interface.
  localparam int FREQ_W  = 16;
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 4;
  localparam int DIST_W  = 18;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEEK  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_BAND_LOW  = 1'b0;
  localparam logic CFG_BAND_HIGH = 1'b1;

  // Band edge reset values in 0.01 kHz units.
  localparam logic [FREQ_W-1:0] BAND_LOW_RST  = 16'd0;
  localparam logic [FREQ_W-1:0] BAND_HIGH_RST = 16'd50000;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [FREQ_W-1:0] freq_t;
  typedef logic signed [DIST_W-1:0] dist_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CUR,
    ST_SCAN,
    ST_LAST,
    ST_PUSH
  } state_t;

  // Result of one request.
  typedef struct packed {
    logic             found;
    logic [INDEX_W-1:0] slot;
    freq_t            freq;
  } result_t;

  // Best candidate seen so far in a scan.
  typedef struct packed {
    logic      any;
    dist_t     arc;
    slot_idx_t slot;
    freq_t     freq;
  } best_t;

endpackage

// ===== design/ccs_dist.sv =====
// Circular distance from the current frequency to one slot, and its compare to the best.
module ccs_dist (
  input  ccs_pkg::freq_t   from_freq,
  input  ccs_pkg::freq_t   to_freq,
  input  logic             seek_up,
  input  ccs_pkg::freq_t   band_low,
  input  ccs_pkg::freq_t   band_high,
  input  ccs_pkg::best_t   best,
  output ccs_pkg::dist_t   arc_dist,
  output logic             better
);

  ccs_pkg::dist_t from_s;
  ccs_pkg::dist_t to_s;
  ccs_pkg::dist_t lo_s;
  ccs_pkg::dist_t hi_s;

  // Widen to signed so out-of-band values give exact, possibly negative distances.
  assign from_s = $signed({2'b00, from_freq});
  assign to_s   = $signed({2'b00, to_freq});
  assign lo_s   = $signed({2'b00, band_low});
  assign hi_s   = $signed({2'b00, band_high});

  // Direct step when the target lies ahead, otherwise wrap through the band edges.
  always_comb begin
    if (to_freq == from_freq) begin
      arc_dist = '0;
    end else if (seek_up) begin
      arc_dist = (to_freq > from_freq) ? (to_s - from_s) : ((hi_s - from_s) + (to_s - lo_s));
    end else begin
      arc_dist = (to_freq < from_freq) ? (from_s - to_s) : ((from_s - lo_s) + (hi_s - to_s));
    end
  end

  // Strictly smaller wins, so the lowest slot keeps a tie.
  assign better = !best.any || (arc_dist < best.arc);

endmodule

// ===== design/circular_channel_seek.sv =====
// Top level of the circular channel seek block: beacon table, scan sequencer, output register.
//
// Requests enter on the in_ channel (valid/stall) and each yields exactly one result on
// the out_ channel. A write or clear updates the slot table at acceptance and its
// all-zero result passes through PUSH to the output register. A seek scans every slot
// frequency out of a single-port synchronous table memory, one slot per cycle, keeping
// the closest candidate; with a current selection it reads the selected slot's
// frequency in the acceptance cycle, before the scan starts. A seek result moves via
// CUR (with a selection), SCAN, LAST and PUSH to the output register. One request is
// in flight at a time, and the next one is taken once the previous result has moved to
// the output register. The output register holds a result while out_stall is high; a
// finished request's result waits in the sequencer and a new request is taken as soon
// as it has moved on. Synchronous reset (rst_n low) clears all valid marks, the
// selection, the output and the band edges (low 0, high 50000); slot frequencies are
// not cleared. Band edges are written through cfg_we/cfg_index/cfg_wdata; the user must
// do so only while the block is idle, as the block does not enforce it.
module circular_channel_seek (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_slot_index,
  input  logic [15:0] in_entry_freq,
  input  logic        in_seek_up,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [3:0]  out_chosen_slot,
  output logic [15:0] out_tuned_freq,
  // Configuration port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam ccs_pkg::slot_idx_t LAST_IDX = ccs_pkg::slot_idx_t'(ccs_pkg::NUM_SLOTS - 1);

  ccs_pkg::state_t    state_r;
  ccs_pkg::state_t    state_nxt;

  ccs_pkg::freq_t     band_low_r;
  ccs_pkg::freq_t     band_high_r;

  ccs_pkg::freq_t     slot_mem [ccs_pkg::NUM_SLOTS];
  ccs_pkg::freq_t     rd_data_r;
  logic               rd_en;
  ccs_pkg::slot_idx_t rd_addr;

  logic [ccs_pkg::NUM_SLOTS-1:0] slot_valid_r;
  logic               have_sel_r;
  ccs_pkg::slot_idx_t sel_r;

  logic               seek_up_r;
  ccs_pkg::freq_t     cur_r;
  ccs_pkg::slot_idx_t cnt_r;
  logic               eval_vld_r;
  ccs_pkg::slot_idx_t eval_idx_r;
  ccs_pkg::best_t     best_r;
  ccs_pkg::best_t     best_nxt;
  ccs_pkg::result_t   res_r;

  logic               out_valid_r;
  ccs_pkg::result_t   out_r;

  logic               in_acc;
  logic               idx_ok;
  ccs_pkg::slot_idx_t in_slot;
  logic               issue;
  logic               cand;
  logic               out_free;
  ccs_pkg::dist_t     arc_dist;
  logic               better;

  // Request decode.
  assign in_stall = (state_r != ccs_pkg::ST_IDLE);
  assign in_acc   = in_valid && (state_r == ccs_pkg::ST_IDLE);
  assign idx_ok   = (int'(in_slot_index) < ccs_pkg::NUM_SLOTS);
  assign in_slot  = ccs_pkg::slot_idx_t'(in_slot_index);
  assign out_free = !out_valid_r || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r  <= ccs_pkg::BAND_LOW_RST;
      band_high_r <= ccs_pkg::BAND_HIGH_RST;
    end else if (cfg_we) begin
      if (cfg_index == ccs_pkg::CFG_BAND_LOW) begin
        band_low_r <= cfg_wdata;
      end else begin
        band_high_r <= cfg_wdata;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ccs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == ccs_pkg::KIND_SEEK) begin
            state_nxt = have_sel_r ? ccs_pkg::ST_CUR : ccs_pkg::ST_SCAN;
          end else begin
            state_nxt = ccs_pkg::ST_PUSH;
          end
        end
      end
      ccs_pkg::ST_CUR:  state_nxt = ccs_pkg::ST_SCAN;
      ccs_pkg::ST_SCAN: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = ccs_pkg::ST_LAST;
        end
      end
      ccs_pkg::ST_LAST: state_nxt = ccs_pkg::ST_PUSH;
      ccs_pkg::ST_PUSH: begin
        if (out_free) begin
          state_nxt = ccs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ccs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer outputs: one table read per scan cycle, plus the selected slot at start.
  always_comb begin
    issue   = (state_r == ccs_pkg::ST_CUR) || (state_r == ccs_pkg::ST_SCAN);
    rd_en   = issue || (in_acc && (in_kind == ccs_pkg::KIND_SEEK) && have_sel_r);
    rd_addr = issue ? cnt_r : sel_r;
    cand    = slot_valid_r[cnt_r] && !(have_sel_r && (sel_r == cnt_r));
  end

  // Slot frequency table: written on accepted writes, read through the registered rd_data_r.
  always_ff @(posedge clk) begin
    if (in_acc && (in_kind == ccs_pkg::KIND_WRITE) && idx_ok) begin
      slot_mem[in_slot] <= in_entry_freq;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem[rd_addr];
    end
  end

  // Distance of the slot read last cycle.
  ccs_dist u_dist (
    .from_freq (cur_r),
    .to_freq   (rd_data_r),
    .seek_up   (seek_up_r),
    .band_low  (band_low_r),
    .band_high (band_high_r),
    .best      (best_r),
    .arc_dist  (arc_dist),
    .better    (better)
  );

  always_comb begin
    best_nxt = best_r;
    if (eval_vld_r && better) begin
      best_nxt.any  = 1'b1;
      best_nxt.arc  = arc_dist;
      best_nxt.slot = eval_idx_r;
      best_nxt.freq = rd_data_r;
    end
  end

  // Scan datapath.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      seek_up_r <= in_seek_up;
      cur_r     <= '0;
      cnt_r     <= '0;
      best_r    <= '0;
    end else begin
      if (state_r == ccs_pkg::ST_CUR) begin
        cur_r <= rd_data_r;
      end
      if (issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
      best_r <= best_nxt;
    end
    eval_idx_r <= cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_vld_r <= 1'b0;
    end else begin
      eval_vld_r <= issue && cand;
    end
  end

  // Valid marks and selection.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      have_sel_r   <= 1'b0;
      sel_r        <= '0;
    end else if (in_acc && idx_ok && (in_kind == ccs_pkg::KIND_WRITE)) begin
      slot_valid_r[in_slot] <= 1'b1;
    end else if (in_acc && idx_ok && (in_kind == ccs_pkg::KIND_CLEAR)) begin
      slot_valid_r[in_slot] <= 1'b0;
      if (have_sel_r && (sel_r == in_slot)) begin
        have_sel_r <= 1'b0;
      end
    end else if ((state_r == ccs_pkg::ST_LAST) && best_nxt.any) begin
      have_sel_r <= 1'b1;
      sel_r      <= best_nxt.slot;
    end
  end

  // Pending result of the request in flight.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= '0;
    end else if (state_r == ccs_pkg::ST_LAST) begin
      res_r.found <= best_nxt.any;
      res_r.slot  <= best_nxt.any ? ccs_pkg::INDEX_W'(best_nxt.slot) : '0;
      res_r.freq  <= best_nxt.any ? best_nxt.freq : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ccs_pkg::ST_PUSH) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ccs_pkg::ST_PUSH) && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_r.found;
  assign out_chosen_slot = out_r.slot;
  assign out_tuned_freq  = out_r.freq;

  // A scan evaluation only happens while the scan is running.
  a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    eval_vld_r |-> ((state_r == ccs_pkg::ST_SCAN) || (state_r == ccs_pkg::ST_LAST)))
    else $error("slot evaluated outside a scan");

  // The current-frequency read only follows a seek taken with a selection.
  a_cur_after_seek: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccs_pkg::ST_CUR) |-> ($past(state_r) == ccs_pkg::ST_IDLE) && have_sel_r)
    else $error("current frequency read without a selection");

  // A seek that finds a beacon leaves it selected.
  a_sel_after_find: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ccs_pkg::ST_LAST) && best_nxt.any) |=> have_sel_r && res_r.found)
    else $error("found beacon not selected");

endmodule

// ===== sim/tb_circular_channel_seek.sv =====
// Self-checking testbench for the circular channel seek block with its beacon scoreboard.
`timescale 1ns / 100ps

import ccs_pkg::*;

// Tracks the beacon table and the tuned selection, and holds the predicted results.
class beacon_scoreboard;
  freq_t     beacon_freq [NUM_SLOTS];
  bit        beacon_live [NUM_SLOTS];
  bit        tuned_on;
  slot_idx_t tuned_slot;
  freq_t     band_lo;
  freq_t     band_hi;
  result_t   tune_q [$];
  int        mismatches;
  int        results_seen;
  int        n_write;
  int        n_clear;
  int        n_seek;
  int        n_unused;
  int        n_tuned;

  function new();
    foreach (beacon_live[i]) begin
      beacon_live[i] = 1'b0;
      beacon_freq[i] = '0;
    end
    tuned_on   = 1'b0;
    tuned_slot = '0;
    band_lo    = BAND_LOW_RST;
    band_hi    = BAND_HIGH_RST;
  endfunction

  function void set_band(logic idx, freq_t value);
    if (idx == CFG_BAND_LOW) begin
      band_lo = value;
    end else begin
      band_hi = value;
    end
  endfunction

  function int pending();
    return tune_q.size();
  endfunction

  // Signed distance around the band from one frequency to another.
  function int arc_distance(int from_f, int to_f, bit up);
    int lo;
    int hi;
    lo = int'(band_lo);
    hi = int'(band_hi);
    if (to_f == from_f) return 0;
    if (up) return (to_f > from_f) ? (to_f - from_f) : ((hi - from_f) + (to_f - lo));
    return (to_f < from_f) ? (from_f - to_f) : ((from_f - lo) + (hi - to_f));
  endfunction

  // Applies one accepted request and queues the result it must produce.
  function void note_request(logic [1:0] kind, logic [3:0] idx, freq_t freq, logic up);
    result_t res;
    int      cur;
    int      best;
    int      d;
    bit      any;
    int      best_slot;
    res = '0;
    if (kind == KIND_WRITE) begin
      n_write++;
      if (int'(idx) < NUM_SLOTS) begin
        beacon_freq[idx] = freq;
        beacon_live[idx] = 1'b1;
      end
    end else if (kind == KIND_CLEAR) begin
      n_clear++;
      if (int'(idx) < NUM_SLOTS) begin
        beacon_live[idx] = 1'b0;
        if (tuned_on && tuned_slot == idx) tuned_on = 1'b0;
      end
    end else if (kind == KIND_SEEK) begin
      n_seek++;
      cur       = tuned_on ? int'(beacon_freq[tuned_slot]) : 0;
      any       = 1'b0;
      best      = 0;
      best_slot = 0;
      // Scan in ascending order so that the lowest slot keeps a tie.
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (beacon_live[i] && !(tuned_on && i == int'(tuned_slot))) begin
          d = arc_distance(cur, int'(beacon_freq[i]), up);
          if (!any || d < best) begin
            any       = 1'b1;
            best      = d;
            best_slot = i;
          end
        end
      end
      if (any) begin
        n_tuned++;
        tuned_on   = 1'b1;
        tuned_slot = slot_idx_t'(best_slot);
        res.found  = 1'b1;
        res.slot   = best_slot[INDEX_W-1:0];
        res.freq   = beacon_freq[best_slot];
      end
    end else begin
      n_unused++;
    end
    tune_q.push_back(res);
  endfunction

  // Compares one accepted result with the oldest prediction.
  function void check_result(logic found, logic [3:0] slot, freq_t freq);
    result_t want;
    results_seen++;
    if (tune_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH: unexpected result found=%0d slot=%0d freq=%0d", found, slot, freq);
      return;
    end
    want = tune_q.pop_front();
    if (found !== want.found || slot !== want.slot || freq !== want.freq) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH @%0t: found exp %0d got %0d, slot exp %0d got %0d, freq exp %0d got %0d",
                 $realtime, want.found, found, want.slot, slot, want.freq, freq);
    end
  endfunction
endclass

module tb_circular_channel_seek;

  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam int         DRAIN        = 24;
  localparam int         CYCLE_LIMIT  = 1000000;

  typedef enum {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [3:0]  in_slot_index;
  logic [15:0] in_entry_freq;
  logic        in_seek_up;
  logic        out_valid;
  logic        out_stall;
  logic        out_found;
  logic [3:0]  out_chosen_slot;
  logic [15:0] out_tuned_freq;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  beacon_scoreboard sb;
  flow_t            flow;
  freq_t            recent_freq [8];
  freq_t            cur_lo;
  freq_t            cur_hi;
  int               band_settings;
  int               cycle_count;
  int               failures;

  circular_channel_seek u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_slot_index   (in_slot_index),
    .in_entry_freq   (in_entry_freq),
    .in_seek_up      (in_seek_up),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_chosen_slot (out_chosen_slot),
    .out_tuned_freq  (out_tuned_freq),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Known values on every input from time zero.
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_WRITE;
    in_slot_index = '0;
    in_entry_freq = '0;
    in_seek_up    = 1'b0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_BAND_LOW;
    cfg_wdata     = '0;
    flow          = FLOW_FREE;
    cycle_count   = 0;
    foreach (recent_freq[i]) recent_freq[i] = '0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_circular_channel_seek: done, errors");
      $finish;
    end
  end

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      case (flow)
        FLOW_RECEIVER_STALL: out_stall <= ($urandom_range(99) < 80);
        FLOW_BOTH:           out_stall <= ($urandom_range(99) < 6);
        default:             out_stall <= 1'b0;
      endcase
    end
  end

  // Result capture on the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_found, out_chosen_slot, out_tuned_freq);
  end

  function automatic int sender_gap();
    int gap;
    int pct;
    gap = 0;
    pct = (flow == FLOW_SENDER_IDLE) ? 80 : (flow == FLOW_BOTH) ? 6 : 0;
    while (gap < 40 && $urandom_range(99) < pct) gap++;
    return gap;
  endfunction

  // Offers one request and waits until it is accepted.
  task automatic send_request(logic [1:0] kind, logic [3:0] idx, freq_t freq, logic up);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_slot_index <= idx;
    in_entry_freq <= freq;
    in_seek_up    <= up;
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, idx, freq, up);
  endtask

  // Drops valid and waits until every predicted result has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Writes both band edges while the block is idle.
  task automatic write_band(freq_t lo, freq_t hi);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BAND_LOW;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= CFG_BAND_HIGH;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_band(CFG_BAND_LOW, lo);
    sb.set_band(CFG_BAND_HIGH, hi);
    cur_lo = lo;
    cur_hi = hi;
    band_settings++;
  endtask

  // One random request, mostly table updates and seeks over a well-populated table.
  task automatic random_request();
    int         roll;
    logic [1:0] kind;
    logic [3:0] idx;
    freq_t      freq;
    logic       up;
    roll = $urandom_range(99);
    if (roll < 38)      kind = KIND_WRITE;
    else if (roll < 52) kind = KIND_CLEAR;
    else if (roll < 96) kind = KIND_SEEK;
    else                kind = KIND_IGNORED;
    idx  = 4'($urandom_range(15));
    up   = 1'($urandom_range(1));
    roll = $urandom_range(99);
    // Reuse earlier frequencies now and then so that equal frequencies and ties occur.
    if (roll < 20)      freq = recent_freq[$urandom_range(7)];
    else if (roll < 30) freq = freq_t'($urandom_range(65535));
    else if (roll < 33) freq = cur_lo;
    else if (roll < 36) freq = cur_hi;
    else                freq = freq_t'($urandom_range(50000));
    if (kind == KIND_WRITE) recent_freq[$urandom_range(7)] = freq;
    send_request(kind, idx, freq, up);
  endtask

  task automatic run_phase(flow_t mode, freq_t lo, freq_t hi, int count, bit hold_midway);
    drain_results();
    repeat (DRAIN) @(posedge clk);
    write_band(lo, hi);
    flow = mode;
    for (int i = 0; i < count; i++) begin
      // Hold the sender until the block has delivered everything.
      if (hold_midway && i == count / 2) drain_results();
      random_request();
    end
  endtask

  initial begin
    sb            = new();
    band_settings = 0;
    cur_lo        = BAND_LOW_RST;
    cur_hi        = BAND_HIGH_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset band.
    send_request(KIND_SEEK,    4'd0,  16'd0,     1'b1);  // seek with an empty table
    send_request(KIND_IGNORED, 4'd9,  16'hFFFF,  1'b1);  // unused kind
    send_request(KIND_WRITE,   4'd0,  16'd0,     1'b0);
    send_request(KIND_WRITE,   4'd15, 16'd50000, 1'b0);
    send_request(KIND_WRITE,   4'd5,  16'd25000, 1'b0);
    send_request(KIND_WRITE,   4'd10, 16'd25000, 1'b0);  // same frequency, higher slot
    send_request(KIND_WRITE,   4'd3,  16'hFFFF,  1'b0);  // above the band
    send_request(KIND_SEEK,    4'd7,  16'd0,     1'b1);  // equal to the zero start point
    send_request(KIND_SEEK,    4'd0,  16'd0,     1'b1);
    send_request(KIND_SEEK,    4'd0,  16'd0,     1'b1);  // equal frequency in another slot
    send_request(KIND_SEEK,    4'd0,  16'd0,     1'b0);
    send_request(KIND_SEEK,    4'd0,  16'd0,     1'b0);
    send_request(KIND_WRITE,   4'd6,  16'hAAAA,  1'b0);
    send_request(KIND_WRITE,   4'd9,  16'h5555,  1'b1);
    send_request(KIND_SEEK,    4'd0,  16'd0,     1'b1);
    send_request(KIND_WRITE,   4'd9,  16'd12345, 1'b1);  // rewrite whatever is selected
    send_request(KIND_WRITE,   4'd6,  16'd12345, 1'b1);
    send_request(KIND_SEEK,    4'd0,  16'd0,     1'b0);
    send_request(KIND_CLEAR,   4'd6,  16'd0,     1'b0);
    send_request(KIND_CLEAR,   4'd9,  16'd0,     1'b0);
    send_request(KIND_SEEK,    4'd0,  16'd0,     1'b1);  // selection may be gone
    send_request(KIND_CLEAR,   4'd12, 16'd0,     1'b0);  // never written
    send_request(KIND_SEEK,    4'd0,  16'd0,     1'b0);
    send_request(KIND_SEEK,    4'd0,  16'd0,     1'b1);

    // Random part across band settings and flow-control modes.
    run_phase(FLOW_FREE,           16'd0,     16'd50000, 70, 1'b0);
    run_phase(FLOW_SENDER_IDLE,    16'd0,     16'd65535, 65, 1'b0);
    run_phase(FLOW_RECEIVER_STALL, 16'd65535, 16'd0,     65, 1'b0);
    run_phase(FLOW_BOTH,           16'd1000,  16'd40000, 65, 1'b0);
    run_phase(FLOW_FREE,           16'd0,     16'd0,     60, 1'b1);
    run_phase(FLOW_RECEIVER_STALL, freq_t'($urandom_range(65535)),
              freq_t'($urandom_range(65535)), 40, 1'b0);
    run_phase(FLOW_SENDER_IDLE,    freq_t'($urandom_range(65535)),
              freq_t'($urandom_range(65535)), 40, 1'b0);

    drain_results();
    flow = FLOW_FREE;
    repeat (DRAIN) @(posedge clk);

    failures = sb.mismatches + sb.pending();
    $display("summary: %0d writes, %0d clears, %0d seeks (%0d tuned), %0d unused-kind requests",
             sb.n_write, sb.n_clear, sb.n_seek, sb.n_tuned, sb.n_unused);
    $display("summary: %0d results checked over %0d band settings, %0d mismatches",
             sb.results_seen, band_settings, failures);
    if (failures == 0) begin
      $display("tb_circular_channel_seek: done, clean");
    end else begin
      $display("tb_circular_channel_seek: done, errors");
    end
    $finish;
  end

endmodule

// ===== circular_channel_seek.f =====
design/ccs_pkg.sv
design/ccs_dist.sv
design/circular_channel_seek.sv
sim/tb_circular_channel_seek.sv
